>>> hw/rtl/fp32as_pkg.sv
// Shared constants and a leading-zero-count helper for the binary32 add/subtract pipeline.
// No dependencies.
`default_nettype none
package fp32as_pkg;
   localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
   localparam logic [22:0] MANT_MASK = 23'h7F_FFFF;
   localparam logic [7:0]  EXP_ONES  = 8'hFF;
   localparam int          EXT_W     = 27;   // 24 significand + guard, round, sticky

   // leading zero count of a 27-bit magnitude (27 when all zero)
   function automatic logic [4:0] lzc27(input logic [EXT_W-1:0] v);
      logic [4:0] n;
      logic       hit;
      n   = 5'd0;
      hit = 1'b0;
      for (int i = EXT_W - 1; i >= 0; i--) begin
         if (!hit && !v[i]) n = n + 5'd1;
         if (v[i]) hit = 1'b1;
      end
      return n;
   endfunction
endpackage
`default_nettype wire

>>> hw/rtl/fp32_add_sub.sv
// Top level: pipelined binary32 adder/subtractor, round to nearest even.
// Depends on fp32as_pkg.
//
// channel | direction | ports
// req     | in        | req_valid, req_ready, req_op_a, req_op_b, req_type
// rsp     | out       | rsp_valid, rsp_ready, rsp_sum_bits
//
// One request per cycle while rsp is not stalled.
// Stages: decode/swap, align, add, normalise, round/pack into the output register.
// Reset clears only the stage valid bits.
// A stall on rsp freezes every stage together; req_ready follows rsp_ready
// whenever the output register holds a result.
`default_nettype none
module fp32_add_sub (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_op_a,
   input  wire logic [31:0] req_op_b,
   input  wire logic        req_type,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_sum_bits
);
   localparam int W = fp32as_pkg::EXT_W;

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: decode, specials, swap ----------------
   logic [31:0] b_eff;
   logic        sa, sb, a_nan, b_nan, spec;
   logic [7:0]  ea, eb, ex_l, ex_s;
   logic [23:0] ma, mb, m_l, m_s;
   logic        s_l, s_s;
   logic [31:0] spec_val;

   always_comb begin
      b_eff = req_op_b ^ {req_type, 31'b0};
      sa = req_op_a[31];
      sb = b_eff[31];
      a_nan = (req_op_a[30:23] == fp32as_pkg::EXP_ONES) && (req_op_a[22:0] != 23'd0);
      b_nan = (b_eff[30:23] == fp32as_pkg::EXP_ONES) && (b_eff[22:0] != 23'd0);
      spec = 1'b1;
      spec_val = req_op_a;
      if (a_nan) spec_val = req_op_a;
      else if (b_nan) spec_val = b_eff;
      else if (req_op_a[30:23] == fp32as_pkg::EXP_ONES) begin
         if (b_eff[30:23] == fp32as_pkg::EXP_ONES && b_eff[22:0] == 23'd0 && sa != sb)
            spec_val = fp32as_pkg::QNAN_BITS;
         else
            spec_val = req_op_a;
      end
      else if (b_eff[30:23] == fp32as_pkg::EXP_ONES) spec_val = b_eff;
      else if (req_op_a[30:0] == 31'd0) spec_val = b_eff;
      else if (b_eff[30:0] == 31'd0) spec_val = req_op_a;
      else spec = 1'b0;
      // subnormals take exponent 1, no hidden bit
      ea = (req_op_a[30:23] == 8'd0) ? 8'd1 : req_op_a[30:23];
      eb = (b_eff[30:23] == 8'd0) ? 8'd1 : b_eff[30:23];
      ma = {req_op_a[30:23] != 8'd0, req_op_a[22:0]};
      mb = {b_eff[30:23] != 8'd0, b_eff[22:0]};
      if (eb > ea) begin
         ex_l = eb; ex_s = ea; m_l = mb; m_s = ma; s_l = sb; s_s = sa;
      end else begin
         ex_l = ea; ex_s = eb; m_l = ma; m_s = mb; s_l = sa; s_s = sb;
      end
   end

   logic        v1_ff, spec1_ff, sl1_ff, ss1_ff;
   logic [31:0] sv1_ff;
   logic [7:0]  e1_ff, d1_ff;
   logic [23:0] ml1_ff, ms1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
      if (adv) begin
         spec1_ff <= spec;
         sv1_ff   <= spec_val;
         e1_ff    <= ex_l;
         d1_ff    <= ex_l - ex_s;
         ml1_ff   <= m_l;
         ms1_ff   <= m_s;
         sl1_ff   <= s_l;
         ss1_ff   <= s_s;
      end
   end

   // ---------------- stage 2: align smaller operand with sticky ----------------
   logic [W-1:0] xs, xs_sh, lost_mask;
   always_comb begin
      xs = {ms1_ff, 3'b000};
      lost_mask = '0;
      xs_sh = '0;
      if (d1_ff >= 8'(W)) xs_sh = {{(W-1){1'b0}}, 1'b1};
      else begin
         lost_mask = ({{(W-1){1'b0}}, 1'b1} << d1_ff[4:0]) - {{(W-1){1'b0}}, 1'b1};
         xs_sh = (xs >> d1_ff[4:0]) | {{(W-1){1'b0}}, |(xs & lost_mask)};
      end
   end

   logic         v2_ff, spec2_ff, sl2_ff, ss2_ff;
   logic [31:0]  sv2_ff;
   logic [7:0]   e2_ff;
   logic [W-1:0] xl2_ff, xs2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
      if (adv) begin
         spec2_ff <= spec1_ff;
         sv2_ff   <= sv1_ff;
         e2_ff    <= e1_ff;
         xl2_ff   <= {ml1_ff, 3'b000};
         xs2_ff   <= xs_sh;
         sl2_ff   <= sl1_ff;
         ss2_ff   <= ss1_ff;
      end
   end

   // ---------------- stage 3: add or subtract magnitudes ----------------
   logic [W:0]   sum;
   logic [W-1:0] res3;
   logic [9:0]   e3;
   logic         sg3, eff_sub;
   always_comb begin
      eff_sub = sl2_ff != ss2_ff;
      e3  = {2'b00, e2_ff};
      sum = '0;
      if (!eff_sub) begin
         sum = {1'b0, xl2_ff} + {1'b0, xs2_ff};
         sg3 = sl2_ff;
         if (sum[W]) begin
            res3 = sum[W:1] | {{(W-1){1'b0}}, sum[0]};
            e3   = e3 + 10'd1;
         end else res3 = sum[W-1:0];
      end else if (xl2_ff >= xs2_ff) begin
         res3 = xl2_ff - xs2_ff; sg3 = sl2_ff;
      end else begin
         res3 = xs2_ff - xl2_ff; sg3 = ss2_ff;
      end
   end

   logic         v3_ff, spec3_ff, sg3_ff;
   logic [31:0]  sv3_ff;
   logic [9:0]   e3_ff;
   logic [W-1:0] r3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
      if (adv) begin
         // exact cancellation gives +0
         spec3_ff <= spec2_ff || (eff_sub && res3 == '0);
         sv3_ff   <= spec2_ff ? sv2_ff : 32'd0;
         e3_ff    <= e3;
         r3_ff    <= res3;
         sg3_ff   <= sg3;
      end
   end

   // ---------------- stage 4: normalise, shift limited by exponent ----------------
   logic [4:0]  lz;
   logic [9:0]  shamt;
   always_comb begin
      lz    = fp32as_pkg::lzc27(r3_ff);
      shamt = ({5'd0, lz} < e3_ff) ? {5'd0, lz} : e3_ff;
   end

   logic         v4_ff, spec4_ff, sg4_ff;
   logic [31:0]  sv4_ff;
   logic [9:0]   e4_ff;
   logic [W-1:0] r4_ff;

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
      if (adv) begin
         spec4_ff <= spec3_ff;
         sv4_ff   <= sv3_ff;
         e4_ff    <= e3_ff - shamt;
         r4_ff    <= r3_ff << shamt[4:0];
         sg4_ff   <= sg3_ff;
      end
   end

   // ---------------- stage 5: round to nearest even, pack ----------------
   logic [24:0] mm;
   logic [9:0]  e5;
   logic [31:0] packed_in;
   always_comb begin
      mm = {1'b0, r4_ff[W-1:3]};
      e5 = e4_ff;
      if (r4_ff[2] && (r4_ff[1] || r4_ff[0] || r4_ff[3])) begin
         mm = mm + 25'd1;
         if (mm[24]) begin
            mm = mm >> 1;
            e5 = e5 + 10'd1;
         end
      end
      if (spec4_ff) packed_in = sv4_ff;
      else if (e5 >= {2'b00, fp32as_pkg::EXP_ONES})
         packed_in = {sg4_ff, fp32as_pkg::EXP_ONES, 23'd0};
      else if (e5 == 10'd0 || !mm[23]) packed_in = {sg4_ff, 31'd0};
      else packed_in = {sg4_ff, e5[7:0], mm[22:0] & fp32as_pkg::MANT_MASK};
   end

   logic        v5_ff;
   logic [31:0] out_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (adv) v5_ff <= v4_ff;
      if (adv) out_ff <= packed_in;
   end

   assign rsp_valid    = v5_ff;
   assign rsp_sum_bits = out_ff;
endmodule
`default_nettype wire
